/* hdl/tcf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the tilt complementary filter.
// Used by tcf_tilt and tilt_complementary_filter_core; no dependencies.
package tcf_pkg;

  // Configuration register indexes
  localparam logic REG_GYRO_GAIN    = 1'b0;
  localparam logic REG_BLEND_WEIGHT = 1'b1;

  // Angle limit in 1/256 degree (+-180 degrees)
  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
  // Q16 unity weight
  localparam logic [17:0] WEIGHT_ONE = 18'd65536;

  // Arctangent table, Q16 degrees, atan(2^-i) rounded to nearest
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 22;

  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Request to the tilt unit: start pulse, b^2 + c^2, numerator axis
  typedef struct packed {
    logic               start;
    logic [31:0]        sum;
    logic signed [15:0] num;
  } tilt_req_t;

  // Response from the tilt unit: done pulse and angle in 1/256 degree
  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } tilt_rsp_t;

endpackage

/* hdl/tcf_tilt.sv */
`timescale 1ns / 1ps
// Accelerometer tilt unit: atan2(num, sqrt(sum)) by a bit-serial square root
// followed by an iterative vectoring CORDIC. Depends on tcf_pkg.
module tcf_tilt #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  tcf_pkg::tilt_req_t req,
  output tcf_pkg::tilt_rsp_t rsp
);
  import tcf_pkg::*;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_SQRT  = 2'd1;
  localparam logic [1:0] T_CORD  = 2'd2;
  localparam logic [1:0] T_ROUND = 2'd3;

  localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

  logic [1:0]            state;
  logic [47:0]           rem;
  logic [47:0]           root;
  logic [47:0]           bitm;
  logic                  num_zero;
  logic signed [26:0]    x;
  logic signed [26:0]    y;
  logic signed [23:0]    z;
  logic [ATAN_IDX_W-1:0] iter;

  logic [47:0]           trial;
  logic [47:0]           rem_next;
  logic [47:0]           root_next;
  logic signed [26:0]    xs;
  logic signed [26:0]    ys;
  logic signed [23:0]    ang;
  logic signed [24:0]    z_rnd;

  // One square root digit per cycle
  always_comb begin
    trial = root + bitm;
    if (rem >= trial) begin
      rem_next  = rem - trial;
      root_next = (root >> 1) + bitm;
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

  // CORDIC shifted terms and rounded angle
  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign ang   = 24'(atan_q16(iter));
  assign z_rnd = 25'(z) + 25'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      rsp.done <= 1'b0;
    end else begin
      // done pulses for one cycle as the angle is written
      rsp.done <= (state == T_ROUND);
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            rem      <= {req.sum, 16'h0000};
            root     <= 48'h0;
            bitm     <= 48'h4000_0000_0000;
            num_zero <= (req.num == 16'sd0);
            y        <= {{3{req.num[15]}}, req.num, 8'h00};
            state    <= T_SQRT;
          end
        end
        T_SQRT: begin
          rem  <= rem_next;
          root <= root_next;
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            x     <= {3'b000, root_next[23:0]};
            z     <= 24'sd0;
            iter  <= '0;
            state <= T_CORD;
          end
        end
        T_CORD: begin
          // rotate toward the x axis
          if (!y[26]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end
          if (iter == LAST_STEP) begin
            state <= T_ROUND;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        T_ROUND: begin
          rsp.angle <= num_zero ? 16'sd0 : z_rnd[23:8];
          state     <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tilt_complementary_filter_core.sv */
`timescale 1ns / 1ps
// Pitch/roll complementary filter: sequencer, shared 18x18 multiplier, state.
// Depends on tcf_pkg and tcf_tilt.
//
//  channel   signals                                        direction
//  cfg       cfg_we, cfg_index, cfg_data                    in
//  in        in_valid/in_ready, accel_x/y/z, gyro_x/y       in
//  out       out_valid/out_ready, pitch_out, roll_out       out
//
// Each item runs through the tilt unit twice, once for pitch and once for roll:
// 24 square root digits plus CORDIC_STEPS rotations each time. in_ready is high
// only when the sequencer is idle, which it becomes as the result is written.
// The result sits in an output register, so a new item is taken while it waits;
// the next item stalls at its end if still untaken.
// Reset is synchronous: angles clear to zero, registers to their defaults.
module tilt_complementary_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] pitch_out,
  output logic signed [16:0] roll_out
);
  import tcf_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQX     = 4'd1;
  localparam logic [3:0] ST_SQZ     = 4'd2;
  localparam logic [3:0] ST_SQY     = 4'd3;
  localparam logic [3:0] ST_TP_GO   = 4'd4;
  localparam logic [3:0] ST_TP_WAIT = 4'd5;
  localparam logic [3:0] ST_TR_GO   = 4'd6;
  localparam logic [3:0] ST_TR_WAIT = 4'd7;
  localparam logic [3:0] ST_GP      = 4'd8;
  localparam logic [3:0] ST_GR      = 4'd9;
  localparam logic [3:0] ST_BP1     = 4'd10;
  localparam logic [3:0] ST_BP2     = 4'd11;
  localparam logic [3:0] ST_BR1     = 4'd12;
  localparam logic [3:0] ST_BR2     = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;
  localparam logic [3:0] ST_OUT     = 4'd15;

  logic [3:0]         state;
  logic [15:0]        gyro_gain;
  logic [16:0]        blend_weight;
  logic signed [16:0] pitch_state;
  logic signed [16:0] roll_state;

  logic signed [15:0] ax, ay, az, gx, gy;
  logic [30:0]        sq_x, sq_y, sq_z;
  logic signed [15:0] tilt_p, tilt_r;
  logic signed [17:0] pred_p, pred_r;
  logic signed [35:0] prod;
  logic signed [35:0] acc;
  logic signed [16:0] new_p, new_r;

  logic signed [17:0] mul_a, mul_b;
  logic signed [17:0] w_sat, w_acc;
  logic signed [35:0] gyro_rnd;
  logic signed [17:0] gyro_step;
  logic signed [36:0] blend_sum;
  logic signed [16:0] blend_ang;

  tilt_req_t tilt_req;
  tilt_rsp_t tilt_rsp;

  // Saturate to +-ANGLE_LIMIT
  function automatic logic signed [16:0] clamp_angle(input logic signed [20:0] v);
    logic signed [20:0] lim;
    lim = 21'(ANGLE_LIMIT);
    if (v > lim) begin
      return ANGLE_LIMIT;
    end else if (v < -lim) begin
      return -ANGLE_LIMIT;
    end
    return v[16:0];
  endfunction

  // Weights: gyro weight capped at one, accelerometer gets the remainder
  always_comb begin
    if (blend_weight[16] && (blend_weight[15:0] != 16'h0)) begin
      w_sat = WEIGHT_ONE;
    end else begin
      w_sat = {1'b0, blend_weight};
    end
    w_acc = WEIGHT_ONE - w_sat;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = 18'sd0;
    mul_b = 18'sd0;
    case (state)
      ST_SQX: begin
        mul_a = 18'(ax);
        mul_b = 18'(ax);
      end
      ST_SQZ: begin
        mul_a = 18'(az);
        mul_b = 18'(az);
      end
      ST_SQY: begin
        mul_a = 18'(ay);
        mul_b = 18'(ay);
      end
      ST_GP: begin
        mul_a = 18'(gx);
        mul_b = {2'b00, gyro_gain};
      end
      ST_GR: begin
        mul_a = 18'(gy);
        mul_b = {2'b00, gyro_gain};
      end
      ST_BP1: begin
        mul_a = w_sat;
        mul_b = pred_p;
      end
      ST_BP2: begin
        mul_a = w_acc;
        mul_b = 18'(tilt_p);
      end
      ST_BR1: begin
        mul_a = w_sat;
        mul_b = pred_r;
      end
      ST_BR2: begin
        mul_a = w_acc;
        mul_b = 18'(tilt_r);
      end
      default: begin
        mul_a = 18'sd0;
        mul_b = 18'sd0;
      end
    endcase
  end

  // Rounded gyro step and rounded blend
  assign gyro_rnd  = prod + 36'sd32768;
  assign gyro_step = gyro_rnd[33:16];
  assign blend_sum = 37'(acc) + 37'(prod) + 37'sd32768;
  assign blend_ang = clamp_angle(blend_sum[36:16]);

  // Tilt unit request
  always_comb begin
    tilt_req.start = (state == ST_TP_GO) || (state == ST_TR_GO);
    if (state == ST_TP_GO) begin
      tilt_req.sum = {1'b0, sq_x} + {1'b0, sq_z};
      tilt_req.num = ay;
    end else begin
      tilt_req.sum = {1'b0, sq_y} + {1'b0, sq_z};
      tilt_req.num = ax;
    end
  end

  tcf_tilt #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_tilt (
    .clk(clk),
    .rst(rst),
    .req(tilt_req),
    .rsp(tilt_rsp)
  );

  assign in_ready = (state == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gain    <= 16'd1281;
      blend_weight <= 17'd64225;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_GAIN:    gyro_gain    <= cfg_data[15:0];
        REG_BLEND_WEIGHT: blend_weight <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Multiplier product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pitch_state <= 17'sd0;
      roll_state  <= 17'sd0;
      out_valid   <= 1'b0;
    end else begin
      // ST_OUT refills the output register itself
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ax    <= accel_x;
            ay    <= accel_y;
            az    <= accel_z;
            gx    <= gyro_x;
            gy    <= gyro_y;
            state <= ST_SQX;
          end
        end
        ST_SQX: state <= ST_SQZ;
        ST_SQZ: begin
          sq_x  <= prod[30:0];
          state <= ST_SQY;
        end
        ST_SQY: begin
          sq_z  <= prod[30:0];
          state <= ST_TP_GO;
        end
        ST_TP_GO: begin
          sq_y  <= prod[30:0];
          state <= ST_TP_WAIT;
        end
        ST_TP_WAIT: begin
          if (tilt_rsp.done) begin
            tilt_p <= tilt_rsp.angle;
            state  <= ST_TR_GO;
          end
        end
        ST_TR_GO: state <= ST_TR_WAIT;
        ST_TR_WAIT: begin
          if (tilt_rsp.done) begin
            tilt_r <= tilt_rsp.angle;
            state  <= ST_GP;
          end
        end
        ST_GP: state <= ST_GR;
        ST_GR: begin
          pred_p <= 18'(pitch_state) + gyro_step;
          state  <= ST_BP1;
        end
        ST_BP1: begin
          pred_r <= 18'(roll_state) + gyro_step;
          state  <= ST_BP2;
        end
        ST_BP2: begin
          acc   <= prod;
          state <= ST_BR1;
        end
        ST_BR1: begin
          new_p <= blend_ang;
          state <= ST_BR2;
        end
        ST_BR2: begin
          acc   <= prod;
          state <= ST_DONE;
        end
        ST_DONE: begin
          new_r <= blend_ang;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the previous result is taken
          if (!out_valid || out_ready) begin
            pitch_state <= new_p;
            roll_state  <= new_r;
            pitch_out   <= new_p;
            roll_out    <= new_r;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
